### src/ant_colony_pheromone_update_top_defines.svh
// ----------------------------------------------------------------------------
// ant colony pheromone update - assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef ANT_COLONY_PHEROMONE_UPDATE_TOP_DEFINES_SVH
`define ANT_COLONY_PHEROMONE_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define ACPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// constants, microcode word and datapath control types of the pheromone block
// ----------------------------------------------------------------------------
`default_nettype none

package acpu_pkg;

  localparam int MAX_CITIES = 64;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_CITIES * MAX_CITIES;

  localparam int CITY_W     = 6;
  localparam int LEN_W      = 32;
  localparam int VAL_W      = 40;
  localparam int KEEP_W     = 17;
  localparam int NUM_W      = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic REG_EVAP_KEEP  = 1'b0;
  localparam logic REG_NUM_CITIES = 1'b1;

  localparam logic [KEEP_W-1:0] EVAP_KEEP_RST  = KEEP_W'(58982);
  localparam logic [NUM_W-1:0]  NUM_CITIES_RST = NUM_W'(64);
  localparam logic [KEEP_W-1:0] KEEP_ONE       = KEEP_W'(65536);
  localparam logic [NUM_W-1:0]  NUM_MAX        = NUM_W'(MAX_CITIES);

  localparam logic [VAL_W-1:0] ONE_Q24   = VAL_W'(64'd16777216);
  localparam logic [VAL_W-1:0] FLOOR_Q24 = VAL_W'(64'd1678);
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  // 100 * 2^32, the deposit numerator
  localparam int QUO_W  = 39;
  localparam int ITER_W = $clog2(QUO_W);
  localparam logic [QUO_W-1:0] DEPOSIT_NUM = QUO_W'(64'd429496729600);

  // evaporation multiply split into two narrow partial products
  localparam int SPLIT_W = 20;
  localparam int MUL_P_W = SPLIT_W + KEEP_W;
  localparam int TOT_W   = MUL_P_W + SPLIT_W;

  // microprogram steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SW_RD    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SW_LO    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SW_HI    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SW_WR    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RPT_RD   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RPT_CAP  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DEP_RD   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DEP_LOAD = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIV      = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DEP_ADD  = 4'd11;
  localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SWEEP_INIT,
    OP_SWEEP_RD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SWEEP_WR,
    OP_ITEM_RD,
    OP_LOAD_DIV,
    OP_DIV,
    OP_ADD_WR,
    OP_REPORT,
    OP_PUSH,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_DEPOSIT,
    C_SWEEP_DONE,
    C_DIV_MORE,
    C_OUT_FREE,
    C_CLEAR_LAST
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic              hold;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic deposit;
    logic sweep_done;
    logic div_more;
    logic out_free;
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

### src/acpu_ram.sv
// ----------------------------------------------------------------------------
// acpu_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module acpu_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/acpu_seq.sv
// ----------------------------------------------------------------------------
// acpu_seq
// microcode sequencer: step counter, control store and jump logic
// ----------------------------------------------------------------------------
`default_nettype none

`include "ant_colony_pheromone_update_top_defines.svh"

module acpu_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire acpu_pkg::dp_status_t  status_i,
  output      acpu_pkg::dp_ctrl_t    ctrl_o
);

  function automatic acpu_pkg::ucode_t rom_word(input logic [acpu_pkg::STEP_W-1:0] step);
    acpu_pkg::ucode_t w;
    w = '{op: acpu_pkg::OP_NOP, cond: acpu_pkg::C_ALWAYS, hold: 1'b0,
          target: acpu_pkg::STEP_IDLE};
    unique case (step)
      acpu_pkg::STEP_IDLE:     w = '{acpu_pkg::OP_NOP, acpu_pkg::C_ACCEPT, 1'b1,
                                     acpu_pkg::STEP_DISPATCH};
      acpu_pkg::STEP_DISPATCH: w = '{acpu_pkg::OP_SWEEP_INIT, acpu_pkg::C_DEPOSIT, 1'b0,
                                     acpu_pkg::STEP_DEP_RD};
      acpu_pkg::STEP_SW_RD:    w = '{acpu_pkg::OP_SWEEP_RD, acpu_pkg::C_SWEEP_DONE, 1'b0,
                                     acpu_pkg::STEP_RPT_RD};
      acpu_pkg::STEP_SW_LO:    w = '{acpu_pkg::OP_MUL_LO, acpu_pkg::C_DEPOSIT, 1'b0,
                                     acpu_pkg::STEP_SW_HI};
      acpu_pkg::STEP_SW_HI:    w = '{acpu_pkg::OP_MUL_HI, acpu_pkg::C_DEPOSIT, 1'b0,
                                     acpu_pkg::STEP_SW_WR};
      acpu_pkg::STEP_SW_WR:    w = '{acpu_pkg::OP_SWEEP_WR, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_SW_RD};
      acpu_pkg::STEP_RPT_RD:   w = '{acpu_pkg::OP_ITEM_RD, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_RPT_CAP};
      acpu_pkg::STEP_RPT_CAP:  w = '{acpu_pkg::OP_REPORT, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_FINISH};
      acpu_pkg::STEP_DEP_RD:   w = '{acpu_pkg::OP_ITEM_RD, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_DEP_LOAD};
      acpu_pkg::STEP_DEP_LOAD: w = '{acpu_pkg::OP_LOAD_DIV, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_DIV};
      acpu_pkg::STEP_DIV:      w = '{acpu_pkg::OP_DIV, acpu_pkg::C_DIV_MORE, 1'b0,
                                     acpu_pkg::STEP_DIV};
      acpu_pkg::STEP_DEP_ADD:  w = '{acpu_pkg::OP_ADD_WR, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_FINISH};
      acpu_pkg::STEP_FINISH:   w = '{acpu_pkg::OP_PUSH, acpu_pkg::C_OUT_FREE, 1'b1,
                                     acpu_pkg::STEP_IDLE};
      acpu_pkg::STEP_CLEAR:    w = '{acpu_pkg::OP_CLEAR, acpu_pkg::C_CLEAR_LAST, 1'b1,
                                     acpu_pkg::STEP_IDLE};
      default:                 w = '{acpu_pkg::OP_NOP, acpu_pkg::C_ALWAYS, 1'b0,
                                     acpu_pkg::STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [acpu_pkg::STEP_W-1:0] pc_q, pc_d;
  acpu_pkg::ucode_t            uw;
  logic                        in_accept;
  logic                        take;

  assign uw         = rom_word(pc_q);
  assign in_ready_o = (pc_q == acpu_pkg::STEP_IDLE);
  assign in_accept  = in_ready_o & in_valid_i;

  always_comb begin
    unique case (uw.cond)
      acpu_pkg::C_ALWAYS:     take = 1'b1;
      acpu_pkg::C_ACCEPT:     take = in_accept;
      acpu_pkg::C_DEPOSIT:    take = status_i.deposit;
      acpu_pkg::C_SWEEP_DONE: take = status_i.sweep_done;
      acpu_pkg::C_DIV_MORE:   take = status_i.div_more;
      acpu_pkg::C_OUT_FREE:   take = status_i.out_free;
      acpu_pkg::C_CLEAR_LAST: take = status_i.clear_last;
      default:                take = 1'b1;
    endcase
  end

  // the sweep multiply steps use the deposit flag only as a never-taken test
  always_comb begin
    priority if (take && !(pc_q == acpu_pkg::STEP_SW_LO || pc_q == acpu_pkg::STEP_SW_HI)) begin
      pc_d = uw.target;
    end else if (uw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + acpu_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= acpu_pkg::STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = '{op: uw.op, accept: in_accept};

  `ACPU_ASSERT_NEXT(a_accept_dispatch, in_accept, pc_q == acpu_pkg::STEP_DISPATCH,
                    "accepted beat did not start dispatch")
  `ACPU_ASSERT_NEXT(a_clear_holds, pc_q == acpu_pkg::STEP_CLEAR && !status_i.clear_last,
                    pc_q == acpu_pkg::STEP_CLEAR, "clearing pass left early")
  `ACPU_ASSERT_NEXT(a_div_loops, pc_q == acpu_pkg::STEP_DIV && status_i.div_more,
                    pc_q == acpu_pkg::STEP_DIV, "divider loop cut short")
  `ACPU_ASSERT_NEXT(a_finish_idle, pc_q == acpu_pkg::STEP_FINISH && status_i.out_free,
                    pc_q == acpu_pkg::STEP_IDLE, "result pushed without return to idle")

endmodule

`default_nettype wire

### src/acpu_dp.sv
// ----------------------------------------------------------------------------
// acpu_dp
// datapath: pheromone store, shared multiplier, radix-2 divider, output register
// ----------------------------------------------------------------------------
`default_nettype none

module acpu_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire acpu_pkg::dp_ctrl_t               ctrl_i,
  output      acpu_pkg::dp_status_t             status_o,
  input  wire logic [acpu_pkg::KEEP_W-1:0]      evap_keep_i,
  input  wire logic [acpu_pkg::NUM_W-1:0]       num_cities_i,
  input  wire logic                             cmd_i,
  input  wire logic [acpu_pkg::CITY_W-1:0]      from_city_i,
  input  wire logic [acpu_pkg::CITY_W-1:0]      to_city_i,
  input  wire logic [acpu_pkg::LEN_W-1:0]       tour_length_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [acpu_pkg::VAL_W-1:0]       entry_value_o,
  output      logic                             saturated_o
);

  localparam int AW = acpu_pkg::ADDR_W;
  localparam int VW = acpu_pkg::VAL_W;
  localparam int IW = acpu_pkg::IDX_W;
  localparam int NW = acpu_pkg::NUM_W;
  localparam int PW = acpu_pkg::MUL_P_W;
  localparam int QW = acpu_pkg::QUO_W;
  localparam int LW = acpu_pkg::LEN_W;
  localparam int RW = acpu_pkg::LEN_W + 1;

  // item and working registers
  logic                              cmd_q, cmd_d;
  logic [AW-1:0]                     addr_q, addr_d;
  logic [LW-1:0]                     len_q, len_d;
  logic [NW-1:0]                     row_q, row_d, col_q, col_d;
  logic [VW-1:0]                     acc_q, acc_d;
  logic                              sat_q, sat_d;
  logic [PW-1:0]                     plo_q, plo_d, phi_q, phi_d;
  logic [RW-1:0]                     rem_q, rem_d;
  logic [QW-1:0]                     quo_q, quo_d;
  logic [acpu_pkg::ITER_W-1:0]       iter_q, iter_d;
  logic [VW-1:0]                     oval_q, oval_d;
  logic                              osat_q, osat_d;
  logic                              ovalid_q, ovalid_d;
  logic [AW-1:0]                     clr_q, clr_d;

  logic [acpu_pkg::KEEP_W-1:0]       keep_eff;
  logic [NW-1:0]                     n_eff;
  logic [acpu_pkg::SPLIT_W-1:0]      mul_a;
  logic [PW-1:0]                     mul_p;
  logic [acpu_pkg::TOT_W-1:0]        total;
  logic [VW-1:0]                     scaled, evap_v;
  logic [RW-1:0]                     trial, trial_sub;
  logic                              q_bit;
  logic [VW-1:0]                     amount;
  logic [VW:0]                       sum_w;
  logic [VW-1:0]                     dep_v;
  logic [NW-1:0]                     col_inc;
  logic [AW-1:0]                     sweep_addr;
  logic                              out_free;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic [VW-1:0]                     ram_wdata, ram_rdata;

  acpu_ram #(
    .WIDTH (VW),
    .DEPTH (acpu_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign keep_eff   = (evap_keep_i > acpu_pkg::KEEP_ONE) ? acpu_pkg::KEEP_ONE : evap_keep_i;
  assign n_eff      = (num_cities_i > acpu_pkg::NUM_MAX) ? acpu_pkg::NUM_MAX : num_cities_i;
  assign sweep_addr = {row_q[IW-1:0], col_q[IW-1:0]};
  assign col_inc    = col_q + NW'(1);

  // shared multiplier, low half then high half of the stored value
  assign mul_a = (ctrl_i.op == acpu_pkg::OP_MUL_LO) ? ram_rdata[acpu_pkg::SPLIT_W-1:0]
                                                    : acc_q[VW-1:acpu_pkg::SPLIT_W];
  assign mul_p = PW'(mul_a) * PW'(keep_eff);

  assign total  = {phi_q, acpu_pkg::SPLIT_W'(0)} + acpu_pkg::TOT_W'(plo_q);
  assign scaled = total[VW+15:16];
  assign evap_v = (scaled < acpu_pkg::FLOOR_Q24) ? acpu_pkg::FLOOR_Q24 : scaled;

  // restoring division step, one quotient bit
  assign trial     = {rem_q[LW-1:0], acpu_pkg::DEPOSIT_NUM[iter_q]};
  assign q_bit     = (trial >= {1'b0, len_q});
  assign trial_sub = trial - {1'b0, len_q};

  assign amount = (len_q == '0) ? acpu_pkg::VALUE_MAX : VW'(quo_q);
  assign sum_w  = {1'b0, acc_q} + {1'b0, amount};
  assign dep_v  = sum_w[VW] ? acpu_pkg::VALUE_MAX : sum_w[VW-1:0];

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = dep_v;
    ram_raddr = addr_q;
    unique case (ctrl_i.op)
      acpu_pkg::OP_SWEEP_RD: ram_raddr = sweep_addr;
      acpu_pkg::OP_SWEEP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = evap_v;
      end
      acpu_pkg::OP_ADD_WR: ram_we = 1'b1;
      acpu_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = acpu_pkg::ONE_Q24;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    len_d    = len_q;
    row_d    = row_q;
    col_d    = col_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    plo_d    = plo_q;
    phi_d    = phi_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    iter_d   = iter_q;
    oval_d   = oval_q;
    osat_d   = osat_q;
    ovalid_d = ovalid_q;
    clr_d    = clr_q;

    if (ctrl_i.accept) begin
      cmd_d  = cmd_i;
      addr_d = {from_city_i[IW-1:0], to_city_i[IW-1:0]};
      len_d  = tour_length_i;
    end

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (ctrl_i.op)
      acpu_pkg::OP_SWEEP_INIT: begin
        row_d = '0;
        col_d = '0;
      end
      acpu_pkg::OP_MUL_LO: begin
        plo_d = mul_p;
        acc_d = ram_rdata;
      end
      acpu_pkg::OP_MUL_HI: phi_d = mul_p;
      acpu_pkg::OP_SWEEP_WR: begin
        if (col_inc == n_eff) begin
          col_d = '0;
          row_d = row_q + NW'(1);
        end else begin
          col_d = col_inc;
        end
      end
      acpu_pkg::OP_LOAD_DIV: begin
        acc_d  = ram_rdata;
        rem_d  = '0;
        quo_d  = '0;
        iter_d = acpu_pkg::ITER_W'(QW - 1);
      end
      acpu_pkg::OP_DIV: begin
        rem_d  = q_bit ? trial_sub : trial;
        quo_d  = {quo_q[QW-2:0], q_bit};
        iter_d = iter_q - acpu_pkg::ITER_W'(1);
      end
      acpu_pkg::OP_ADD_WR: begin
        acc_d = dep_v;
        sat_d = sum_w[VW];
      end
      acpu_pkg::OP_REPORT: begin
        acc_d = ram_rdata;
        sat_d = 1'b0;
      end
      acpu_pkg::OP_PUSH: begin
        if (out_free) begin
          oval_d   = acc_q;
          osat_d   = sat_q;
          ovalid_d = 1'b1;
        end
      end
      acpu_pkg::OP_CLEAR: clr_d = clr_q + AW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    len_q  <= len_d;
    row_q  <= row_d;
    col_q  <= col_d;
    acc_q  <= acc_d;
    sat_q  <= sat_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    iter_q <= iter_d;
    oval_q <= oval_d;
    osat_q <= osat_d;
  end

  assign status_o = '{
    deposit:    cmd_q,
    sweep_done: (row_q >= n_eff),
    div_more:   (iter_q != '0),
    out_free:   out_free,
    clear_last: (clr_q == {AW{1'b1}})
  };

  assign out_valid_o   = ovalid_q;
  assign entry_value_o = oval_q;
  assign saturated_o   = osat_q;

endmodule

`default_nettype wire

### src/ant_colony_pheromone_update_top.sv
// deposit: an accepted beat runs the dispatch, read, divider load, divider, add and
// finish steps, the divider retiring one quotient bit a step; evaporate: each of the
// n*n entries of n active cities runs the read, low multiply, high multiply and write
// steps; one beat at a time; after reset a clearing pass writes 1.0 to all 4096 entries
// and no beat is accepted until it ends; configuration writes are taken throughout
// ----------------------------------------------------------------------------
// ant_colony_pheromone_update_top
// pheromone matrix with evaporate and deposit commands, apb configuration
// ----------------------------------------------------------------------------
`default_nettype none

module ant_colony_pheromone_update_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // apb configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [acpu_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [acpu_pkg::APB_DATA_W-1:0]      pwdata,
  output      logic [acpu_pkg::APB_DATA_W-1:0]      prdata,
  output      logic                                 pready,
  // input stream
  input  wire logic                                 s_axis_tvalid_i,
  output      logic                                 s_axis_tready_o,
  // from_city [5:0], to_city [11:6], tour_length [43:12], zero fill [47:44]
  input  wire logic [acpu_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // cmd [0]
  input  wire logic                                 s_axis_tuser_i,
  // result stream
  output      logic                                 m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // entry_value [39:0]
  output      logic [acpu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // saturated [0]
  output      logic                                 m_axis_tuser_o
);

  logic [acpu_pkg::KEEP_W-1:0] evap_keep_q, evap_keep_d;
  logic [acpu_pkg::NUM_W-1:0]  num_cities_q, num_cities_d;
  logic                        cfg_wr;
  logic                        reg_sel;

  acpu_pkg::dp_ctrl_t   ctrl;
  acpu_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_comb begin
    evap_keep_d  = evap_keep_q;
    num_cities_d = num_cities_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        acpu_pkg::REG_EVAP_KEEP:  evap_keep_d  = pwdata[acpu_pkg::KEEP_W-1:0];
        acpu_pkg::REG_NUM_CITIES: num_cities_d = pwdata[acpu_pkg::NUM_W-1:0];
        default:                  evap_keep_d  = evap_keep_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      acpu_pkg::REG_EVAP_KEEP:  prdata = acpu_pkg::APB_DATA_W'(evap_keep_q);
      acpu_pkg::REG_NUM_CITIES: prdata = acpu_pkg::APB_DATA_W'(num_cities_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evap_keep_q  <= acpu_pkg::EVAP_KEEP_RST;
      num_cities_q <= acpu_pkg::NUM_CITIES_RST;
    end else begin
      evap_keep_q  <= evap_keep_d;
      num_cities_q <= num_cities_d;
    end
  end

  acpu_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  acpu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .evap_keep_i   (evap_keep_q),
    .num_cities_i  (num_cities_q),
    .cmd_i         (s_axis_tuser_i),
    .from_city_i   (s_axis_tdata_i[5:0]),
    .to_city_i     (s_axis_tdata_i[11:6]),
    .tour_length_i (s_axis_tdata_i[43:12]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .entry_value_o (m_axis_tdata_o),
    .saturated_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

### tb/sv/acpu_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_tb_pkg
// command codes shared by the pheromone stimulus and the result checker
// ----------------------------------------------------------------------------
package acpu_tb_pkg;

  // carried on s_axis_tuser_i
  typedef enum logic {
    CMD_EVAPORATE = 1'b0,
    CMD_DEPOSIT   = 1'b1
  } pheromone_cmd_e;

endpackage

### tb/sv/pheromone_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_checker
// follows the apb register writes and the input beats with its own copy of the
// pheromone matrix, queues the entry each beat should report and compares it
// with every result beat
// ----------------------------------------------------------------------------
module pheromone_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic                             pready_i,
  input  logic [acpu_pkg::APB_ADDR_W-1:0]  paddr_i,
  input  logic [acpu_pkg::APB_DATA_W-1:0]  pwdata_i,
  input  logic                             in_tvalid_i,
  input  logic                             in_tready_i,
  // from_city [5:0], to_city [11:6], tour_length [43:12], zero fill [47:44]
  input  logic [acpu_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  // cmd [0]
  input  logic                             in_tuser_i,
  input  logic                             out_tvalid_i,
  input  logic                             out_tready_i,
  // entry_value [39:0]
  input  logic [acpu_pkg::OUT_TDATA_W-1:0] out_tdata_i,
  // saturated [0]
  input  logic                             out_tuser_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_count_o
);
  import acpu_pkg::*;
  import acpu_tb_pkg::*;

  typedef struct {
    logic [CITY_W-1:0] row;
    logic [CITY_W-1:0] col;
    logic [VAL_W-1:0]  entry;
    logic              sat;
  } entry_report_t;

  logic [VAL_W-1:0]  pheromone_mx [DEPTH];
  logic [KEEP_W-1:0] keep_q;
  logic [NUM_W-1:0]  cities_q;
  entry_report_t     expected_entry_q [$];

  function automatic entry_report_t apply_pheromone_step(input pheromone_cmd_e cmd,
                                                         input logic [CITY_W-1:0] row,
                                                         input logic [CITY_W-1:0] col,
                                                         input logic [LEN_W-1:0] len);
    entry_report_t res;
    logic [63:0]   keep;
    logic [63:0]   side;
    logic [63:0]   prod;
    logic [63:0]   amount;
    logic [63:0]   sum;
    int unsigned   slot;
    int unsigned   idx;
    int unsigned   r;
    int unsigned   c;
    slot = row * MAX_CITIES + col;
    res.row = row;
    res.col = col;
    res.sat = 1'b0;
    if (cmd == CMD_EVAPORATE) begin
      // keep factor clamps at 1.0, sweep side clamps at the matrix size
      keep = (keep_q > KEEP_ONE) ? 64'(KEEP_ONE) : 64'(keep_q);
      side = (cities_q > NUM_MAX) ? 64'(NUM_MAX) : 64'(cities_q);
      for (r = 0; r < side; r++) begin
        for (c = 0; c < side; c++) begin
          idx  = r * MAX_CITIES + c;
          prod = (64'(pheromone_mx[idx]) * keep) >> 16;
          if (prod < 64'(FLOOR_Q24)) begin
            prod = 64'(FLOOR_Q24);
          end
          pheromone_mx[idx] = prod[VAL_W-1:0];
        end
      end
    end else begin
      amount = (len == '0) ? 64'(VALUE_MAX) : 64'(DEPOSIT_NUM) / 64'(len);
      sum    = 64'(pheromone_mx[slot]) + amount;
      if (sum > 64'(VALUE_MAX)) begin
        sum     = 64'(VALUE_MAX);
        res.sat = 1'b1;
      end
      pheromone_mx[slot] = sum[VAL_W-1:0];
    end
    res.entry = pheromone_mx[slot];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_report_t exp_r;
    entry_report_t pred_r;
    int            k;
    if (!rst_ni) begin
      for (k = 0; k < DEPTH; k++) begin
        pheromone_mx[k] = ONE_Q24;
      end
      keep_q   = EVAP_KEEP_RST;
      cities_q = NUM_CITIES_RST;
      expected_entry_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_EVAP_KEEP) begin
          keep_q = pwdata_i[KEEP_W-1:0];
        end else begin
          cities_q = pwdata_i[NUM_W-1:0];
        end
      end
      if (out_tvalid_i && out_tready_i) begin
        if (expected_entry_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected result beat entry=%0d sat=%0b", $realtime,
                     out_tdata_i, out_tuser_i);
          end
          mismatch_count_o++;
        end else begin
          exp_r = expected_entry_q.pop_front();
          if (out_tdata_i !== exp_r.entry || out_tuser_i !== exp_r.sat) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: entry (%0d,%0d) expected %0d sat %0b, got %0d sat %0b",
                       $realtime, exp_r.row, exp_r.col, exp_r.entry, exp_r.sat,
                       out_tdata_i, out_tuser_i);
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_tvalid_i && in_tready_i) begin
        pred_r = apply_pheromone_step(pheromone_cmd_e'(in_tuser_i),
                                      in_tdata_i[5:0],
                                      in_tdata_i[11:6],
                                      in_tdata_i[43:12]);
        expected_entry_q = {expected_entry_q, pred_r};
      end
      pending_count_o = expected_entry_q.size();
    end
  end

endmodule

### tb/sv/tb_ant_colony_pheromone_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ant_colony_pheromone_update_top
// drives evaporate and deposit beats and register writes into the pheromone
// block with random gaps and result stalls, directed corners first, then
// random tour walks over changing matrix sizes and keep factors
// ----------------------------------------------------------------------------
module tb_ant_colony_pheromone_update_top;
  import acpu_pkg::*;
  import acpu_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 850;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // from_city [5:0], to_city [11:6], tour_length [43:12], zero fill [47:44]
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  // cmd [0]
  logic                   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // entry_value [39:0]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // saturated [0]
  logic                   m_axis_tuser_o;

  int unsigned            mismatch_count;
  int unsigned            pending_count;
  int unsigned            cycle_count;
  logic                   send_idle;
  logic                   recv_idle;

  ant_colony_pheromone_update_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  pheromone_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_tvalid_i      (s_axis_tvalid_i),
    .in_tready_i      (s_axis_tready_o),
    .in_tdata_i       (s_axis_tdata_i),
    .in_tuser_i       (s_axis_tuser_i),
    .out_tvalid_i     (m_axis_tvalid_o),
    .out_tready_i     (m_axis_tready_i),
    .out_tdata_i      (m_axis_tdata_o),
    .out_tuser_i      (m_axis_tuser_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: either always ready, or a random stall once a beat shows up
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    forever begin
      if (!recv_idle) begin
        m_axis_tready_i = 1'b1;
        do @(posedge clk_i); while (!m_axis_tvalid_o);
        @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid_o);
        @(negedge clk_i);
        stall = $urandom_range(0, 6);
        repeat (stall) @(negedge clk_i);
        m_axis_tready_i = 1'b1;
        @(posedge clk_i);
        @(negedge clk_i);
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'({idx, 2'b00});
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // called and left at a falling edge; valid stays up when the next beat follows
  task automatic send_item(input pheromone_cmd_e cmd, input logic [CITY_W-1:0] row,
                           input logic [CITY_W-1:0] col, input logic [LEN_W-1:0] len);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = cmd;
    s_axis_tdata_i  = {4'b0000, len, col, row};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [CITY_W-1:0] pick_city(input logic [NUM_W-1:0] cities);
    int unsigned side;
    side = (cities > NUM_MAX) ? MAX_CITIES : cities;
    if (side == 0 || $urandom_range(0, 4) == 0) begin
      return CITY_W'($urandom_range(0, MAX_CITIES - 1));
    end
    return CITY_W'($urandom_range(0, side - 1));
  endfunction

  function automatic logic [LEN_W-1:0] pick_tour_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return LEN_W'($urandom_range(1, 16));
      3, 4:    return LEN_W'($urandom_range(17, 4096));
      5:       return LEN_W'($urandom);
      6:       return 32'hFFFF_FFFF - LEN_W'($urandom_range(0, 255));
      default: return LEN_W'($urandom_range(256, 1 << 20));
    endcase
  endfunction

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return KEEP_ONE;
      2:       return KEEP_W'($urandom_range(65537, 131071));
      default: return KEEP_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [NUM_W-1:0]  cities;
    logic [CITY_W-1:0] walk;
    logic [CITY_W-1:0] next_city;
    pheromone_cmd_e    cmd;
    int unsigned       random_sent;
    int unsigned       phase_len;

    cycle_count     = 0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    rst_ni          = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: corners of the fields, saturation, a full sweep
    send_item(CMD_DEPOSIT, 6'd0, 6'd0, 32'd0);
    send_item(CMD_DEPOSIT, 6'd0, 6'd0, 32'd1);
    send_item(CMD_DEPOSIT, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_item(CMD_DEPOSIT, 6'd5, 6'd9, 32'd1);
    send_item(CMD_DEPOSIT, 6'd63, 6'd0, 32'd256);
    send_item(CMD_DEPOSIT, 6'd0, 6'd63, 32'hAAAA_AAAA);
    send_item(CMD_DEPOSIT, 6'd42, 6'd21, 32'h5555_5555);
    send_item(CMD_EVAPORATE, 6'd0, 6'd0, 32'd0);
    send_item(CMD_EVAPORATE, 6'd63, 6'd63, 32'hFFFF_FFFF);

    // zero keep drives the corner to the floor, entries outside stay put
    drain_results();
    write_reg(REG_EVAP_KEEP, 32'd0);
    write_reg(REG_NUM_CITIES, 32'd2);
    send_item(CMD_EVAPORATE, 6'd1, 6'd1, 32'd0);
    send_item(CMD_EVAPORATE, 6'd2, 6'd2, 32'd0);
    send_item(CMD_DEPOSIT, 6'd1, 6'd0, 32'd0);

    drain_results();
    write_reg(REG_EVAP_KEEP, 32'(KEEP_ONE));
    write_reg(REG_NUM_CITIES, 32'd3);
    send_item(CMD_EVAPORATE, 6'd1, 6'd0, 32'd0);

    // keep above one, single-entry sweep, empty sweep
    drain_results();
    write_reg(REG_EVAP_KEEP, 32'd131071);
    write_reg(REG_NUM_CITIES, 32'd1);
    send_item(CMD_EVAPORATE, 6'd0, 6'd0, 32'd0);
    send_item(CMD_EVAPORATE, 6'd0, 6'd1, 32'd0);
    drain_results();
    write_reg(REG_NUM_CITIES, 32'd0);
    send_item(CMD_EVAPORATE, 6'd0, 6'd0, 32'd0);

    // city count beyond the matrix clamps to the whole matrix
    drain_results();
    write_reg(REG_EVAP_KEEP, 32'd32768);
    write_reg(REG_NUM_CITIES, 32'd127);
    send_item(CMD_EVAPORATE, 6'd63, 6'd63, 32'd0);
    send_item(CMD_DEPOSIT, 6'd63, 6'd63, 32'd3);

    // random phases: mostly tour walks over the active corner between sweeps
    random_sent = 0;
    walk        = '0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      write_reg(REG_EVAP_KEEP, 32'(pick_keep()));
      case ($urandom_range(0, 5))
        0:       cities = NUM_W'(2);
        1:       cities = NUM_W'($urandom_range(9, 16));
        default: cities = NUM_W'($urandom_range(2, 8));
      endcase
      write_reg(REG_NUM_CITIES, 32'(cities));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 90);
      if (phase_len > RANDOM_ITEMS - random_sent) begin
        phase_len = RANDOM_ITEMS - random_sent;
      end
      repeat (phase_len) begin
        cmd       = ($urandom_range(0, 4) == 0) ? CMD_EVAPORATE : CMD_DEPOSIT;
        next_city = pick_city(cities);
        if ($urandom_range(0, 6) == 0) begin
          walk = pick_city(cities);
        end
        send_item(cmd, walk, next_city, pick_tour_length());
        walk = next_city;
        random_sent++;
      end
    end

    s_axis_tvalid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
